// ----- hw/rtl/aes_ctr_pkg.sv -----
package aes_ctr_pkg;

    localparam int BLK_W = 128;
    localparam int CNT_W = 5;
    localparam int NUM_ROUNDS = 10;
    localparam logic [7:0] RC_INIT = 8'h01;
    localparam logic [7:0] GF_POLY = 8'h1b;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_IV_HIGH  = 2'd2;
    localparam logic [1:0] REG_IV_LOW   = 2'd3;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Byte i of a block sits at bits [127-8i -: 8].
    function automatic logic [7:0] get_byte(input logic [127:0] b, input int i);
        get_byte = b[127 - 8 * i -: 8];
    endfunction

    function automatic logic [7:0] gf_dbl(input logic [7:0] v);
        gf_dbl = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    // One forward key-schedule step: round key r -> round key r+1.
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        key_step = {w0, w1, w2, w3};
    endfunction

endpackage

// ----- hw/rtl/aes_ctr_round.sv -----
module aes_ctr_round (
    input  logic [127:0] i_state,
    input  logic [127:0] i_round_key,
    input  logic         i_last,
    output logic [127:0] o_state
);

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [127:0] v;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = aes_ctr_pkg::get_byte(i_state, i);
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4 * c + r] = aes_ctr_pkg::SBOX[s[4 * ((c + r) % 4) + r]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            m[4*c]   = aes_ctr_pkg::gf_dbl(t[4*c]) ^ aes_ctr_pkg::gf_dbl(t[4*c+1])
                       ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4*c+1] = t[4*c] ^ aes_ctr_pkg::gf_dbl(t[4*c+1]) ^ aes_ctr_pkg::gf_dbl(t[4*c+2])
                       ^ t[4*c+2] ^ t[4*c+3];
            m[4*c+2] = t[4*c] ^ t[4*c+1] ^ aes_ctr_pkg::gf_dbl(t[4*c+2])
                       ^ aes_ctr_pkg::gf_dbl(t[4*c+3]) ^ t[4*c+3];
            m[4*c+3] = aes_ctr_pkg::gf_dbl(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2]
                       ^ aes_ctr_pkg::gf_dbl(t[4*c+3]);
        end
        for (int i = 0; i < 16; i++) begin
            v[127 - 8 * i -: 8] = i_last ? t[i] : m[i];
        end
        o_state = v ^ i_round_key;
    end

endmodule

// ----- hw/rtl/aes128_ctr_keystream_xor_unit.sv -----
// Order of work for an item: with start_req, ten key-schedule steps run first, one per cycle,
// into the round-key memory; then the load state, ten rounds on the single shared round unit
// and the output state, which holds until the result is taken. The unit accepts a new item
// only in the idle state, so it takes no new item before the last result has been taken.
// Reset: synchronous active low; clears control, config registers and counter.
// The round-key memory holds no reset value; it is valid after the first start.
module aes128_ctr_keystream_xor_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // data_high[63:0], data_low[127:64], byte_count[132:128]
    input  logic         s_axis_tuser,  // start_req
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,  // result_high[63:0], result_low[127:64], valid_bytes[132:128]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_KEY  = 5'b00010,
        S_LOAD = 5'b00100,
        S_RND  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state       r_state;
    logic [63:0]  r_cfg [4];
    logic [127:0] r_ctr;
    logic [127:0] r_st;
    logic [127:0] r_kexp;
    logic [7:0]   r_rc;
    logic [3:0]   r_rnd;
    logic [127:0] r_data;
    logic [4:0]   r_cnt;
    logic [127:0] r_rk;
    logic [127:0] r_kmem [11];
    logic [135:0] r_out;
    logic [127:0] w_rnd;
    logic [127:0] w_knext;
    logic [1:0]   w_idx;
    logic         w_wr;
    logic [3:0]   w_kaddr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:3];
    assign w_wr   = psel && penable && pwrite;
    assign prdata = r_cfg[w_idx];
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_out;
    assign w_knext = aes_ctr_pkg::key_step(r_kexp, r_rc);

    aes_ctr_round u_round (
        .i_state     (r_st),
        .i_round_key (r_rk),
        .i_last      (r_rnd == 4'(aes_ctr_pkg::NUM_ROUNDS)),
        .o_state     (w_rnd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (w_wr) begin
            r_cfg[w_idx] <= pwdata;
        end
    end

    // Address the key for the next round, so that the registered read has it ready when that round starts.
    always_comb begin
        case (r_state)
            S_LOAD: w_kaddr = 4'd1;
            S_RND: begin
                w_kaddr = (r_rnd == 4'(aes_ctr_pkg::NUM_ROUNDS)) ? 4'd0 : r_rnd + 4'd1;
            end
            default: w_kaddr = 4'd0;
        endcase
    end

    // Round-key memory: written during expansion, registered read.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid && s_axis_tuser) begin
            r_kmem[0] <= {r_cfg[aes_ctr_pkg::REG_KEY_HIGH], r_cfg[aes_ctr_pkg::REG_KEY_LOW]};
        end else if (r_state == S_KEY) begin
            r_kmem[r_rnd + 4'd1] <= w_knext;
        end
        r_rk <= r_kmem[w_kaddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ctr   <= '0;
            r_rnd   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_data <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                        r_cnt  <= (s_axis_tdata[132:128] > 5'd16) ? 5'd16
                                                                   : s_axis_tdata[132:128];
                        r_rnd  <= '0;
                        if (s_axis_tuser) begin
                            r_kexp  <= {r_cfg[aes_ctr_pkg::REG_KEY_HIGH],
                                        r_cfg[aes_ctr_pkg::REG_KEY_LOW]};
                            r_rc    <= aes_ctr_pkg::RC_INIT;
                            r_ctr   <= {r_cfg[aes_ctr_pkg::REG_IV_HIGH],
                                        r_cfg[aes_ctr_pkg::REG_IV_LOW]};
                            r_state <= S_KEY;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_KEY: begin
                    r_kexp <= w_knext;
                    r_rc   <= aes_ctr_pkg::gf_dbl(r_rc);
                    if (r_rnd == 4'(aes_ctr_pkg::NUM_ROUNDS - 1)) begin
                        r_rnd   <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_rnd <= r_rnd + 4'd1;
                    end
                end
                S_LOAD: begin
                    // r_rk holds round key 0 here.
                    r_st    <= r_ctr ^ r_rk;
                    r_rnd   <= 4'd1;
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_st <= w_rnd;
                    if (r_rnd == 4'(aes_ctr_pkg::NUM_ROUNDS)) begin
                        // Byte 0 lands at the top of result_high in bits 63:56.
                        for (int i = 0; i < 16; i++) begin
                            r_out[((i < 8) ? (63 - 8 * i) : (191 - 8 * i)) -: 8]
                                <= (5'(i) < r_cnt)
                                ? (aes_ctr_pkg::get_byte(r_data, i)
                                   ^ aes_ctr_pkg::get_byte(w_rnd, i)) : 8'h00;
                        end
                        r_out[135:128] <= {3'b000, r_cnt};
                        r_ctr   <= r_ctr + 128'd1;
                        r_state <= S_OUT;
                    end else begin
                        r_rnd <= r_rnd + 4'd1;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
